>>> sv/fspc_pkg.sv
// shared types, opcodes and decode helpers for the five-stage pipelined cpu
package fspc_pkg;

   localparam logic [24:0] NOOP_WORD = 25'h1c00000;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_NAND = 3'd1;
   localparam logic [2:0] OP_LW   = 3'd2;
   localparam logic [2:0] OP_SW   = 3'd3;
   localparam logic [2:0] OP_BEQ  = 3'd4;
   localparam logic [2:0] OP_HALT = 3'd6;
   localparam logic [2:0] OP_NOOP = 3'd7;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic        command;
      logic [15:0] load_address;
      logic signed [31:0] load_word;
   } req_type;

   typedef struct packed {
      logic        halted;
      logic [31:0] cycle_count;
      logic [15:0] program_counter;
      logic        reg_write_valid;
      logic [2:0]  reg_write_index;
      logic signed [31:0] reg_write_value;
      logic        store_valid;
      logic [15:0] store_address;
      logic signed [31:0] store_value;
   } rsp_type;

   function automatic logic [2:0] op_of(input logic [24:0] w);
      return w[24:22];
   endfunction

   function automatic logic [2:0] ra_of(input logic [24:0] w);
      return w[21:19];
   endfunction

   function automatic logic [2:0] rb_of(input logic [24:0] w);
      return w[18:16];
   endfunction

   function automatic logic [2:0] dst_of(input logic [24:0] w);
      return w[2:0];
   endfunction

   function automatic logic [31:0] sext16(input logic [24:0] w);
      return {{16{w[15]}}, w[15:0]};
   endfunction

   // take the stage's data if that stage writes the register (a lw stage only when allow_lw is set)
   function automatic logic [31:0] fwd(input logic [2:0] r, input logic [31:0] val,
                                       input logic [24:0] ins, input logic [31:0] data,
                                       input logic allow_lw);
      logic [31:0] res;
      res = val;
      if ((op_of(ins) == OP_ADD || op_of(ins) == OP_NAND) && dst_of(ins) == r) begin
         res = data;
      end else if (allow_lw && op_of(ins) == OP_LW && rb_of(ins) == r) begin
         res = data;
      end
      return res;
   endfunction

endpackage

>>> sv/five_stage_pipelined_cpu.sv
// five-stage pipelined cpu: one load or tick beat per cycle while results are taken
// latency: a result beat appears the cycle after its request beat is accepted
// throughput: one beat per cycle while results are taken; memories are read ahead
//   at next-state addresses, so fetch and data load each use one read port per cycle
// reset: pipeline latches hold noop, pc, registers, counter and halt clear; memories
//   are not cleared and must be loaded before they are read
module five_stage_pipelined_cpu #(
   parameter int MEMORY_WORDS = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fspc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fspc_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MEMORY_WORDS);

   logic [15:0] pc_ff, pc_in;
   logic [24:0] if_ins_ff, if_ins_in;
   logic [15:0] if_nxt_ff, if_nxt_in;
   logic [24:0] id_ins_ff, id_ins_in;
   logic [15:0] id_nxt_ff, id_nxt_in;
   logic [31:0] id_a_ff, id_a_in, id_b_ff, id_b_in, id_off_ff, id_off_in;
   logic [24:0] ex_ins_ff, ex_ins_in;
   logic [15:0] ex_tgt_ff, ex_tgt_in;
   logic [31:0] ex_alu_ff, ex_alu_in, ex_b_ff, ex_b_in;
   logic [24:0] mem_ins_ff, mem_ins_in;
   logic [31:0] mem_dat_ff, mem_dat_in;
   logic [24:0] wb_ins_ff, wb_ins_in;
   logic [31:0] wb_dat_ff, wb_dat_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        halt_ff, halt_in;
   logic [31:0] rf_ff [8];
   logic        rsp_valid_ff, rsp_valid_in;
   fspc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        req_fire, tick, is_load, stall;
   logic [15:0] faddr, seq;
   logic [31:0] imem_rdata, dmem_rdata, a, b;
   logic [2:0]  ld;
   logic        wr_valid;
   logic [2:0]  wr_idx;
   logic        st_valid;
   logic [15:0] ifetch_addr;
   logic        imem_we, dmem_we;
   logic [AW-1:0] dmem_waddr;
   logic [31:0] dmem_wdata;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_load   = req_fire && req_data.command == fspc_pkg::CMD_LOAD;
   assign tick      = req_fire && req_data.command == fspc_pkg::CMD_TICK && !halt_ff;

   always_comb begin
      faddr = (fspc_pkg::op_of(ex_ins_ff) == fspc_pkg::OP_BEQ) ? ex_tgt_ff : pc_ff;
      seq   = faddr + 16'd1;

      stall = 1'b0;
      ld    = fspc_pkg::rb_of(id_ins_ff);
      if (fspc_pkg::op_of(id_ins_ff) == fspc_pkg::OP_LW) begin
         if (fspc_pkg::op_of(if_ins_ff) == fspc_pkg::OP_LW) begin
            stall = (ld == fspc_pkg::ra_of(if_ins_ff));
         end else if (fspc_pkg::op_of(if_ins_ff) != fspc_pkg::OP_NOOP) begin
            stall = (ld == fspc_pkg::ra_of(if_ins_ff)) || (ld == fspc_pkg::rb_of(if_ins_ff));
         end
      end

      // nearest stage wins
      a = id_a_ff;
      b = id_b_ff;
      a = fspc_pkg::fwd(fspc_pkg::ra_of(id_ins_ff), a, wb_ins_ff, wb_dat_ff, 1'b1);
      b = fspc_pkg::fwd(fspc_pkg::rb_of(id_ins_ff), b, wb_ins_ff, wb_dat_ff, 1'b1);
      a = fspc_pkg::fwd(fspc_pkg::ra_of(id_ins_ff), a, mem_ins_ff, mem_dat_ff, 1'b1);
      b = fspc_pkg::fwd(fspc_pkg::rb_of(id_ins_ff), b, mem_ins_ff, mem_dat_ff, 1'b1);
      a = fspc_pkg::fwd(fspc_pkg::ra_of(id_ins_ff), a, ex_ins_ff, ex_alu_ff, 1'b0);
      b = fspc_pkg::fwd(fspc_pkg::rb_of(id_ins_ff), b, ex_ins_ff, ex_alu_ff, 1'b0);

      wr_valid = 1'b0;
      wr_idx   = 3'd0;
      if (fspc_pkg::op_of(mem_ins_ff) == fspc_pkg::OP_LW) begin
         wr_valid = 1'b1;
         wr_idx   = fspc_pkg::rb_of(mem_ins_ff);
      end else if (fspc_pkg::op_of(mem_ins_ff) == fspc_pkg::OP_ADD ||
                   fspc_pkg::op_of(mem_ins_ff) == fspc_pkg::OP_NAND) begin
         wr_valid = 1'b1;
         wr_idx   = fspc_pkg::dst_of(mem_ins_ff);
      end
      st_valid = fspc_pkg::op_of(ex_ins_ff) == fspc_pkg::OP_SW;

      pc_in      = pc_ff;
      if_ins_in  = if_ins_ff;
      if_nxt_in  = if_nxt_ff;
      id_ins_in  = id_ins_ff;
      id_nxt_in  = id_nxt_ff;
      id_a_in    = id_a_ff;
      id_b_in    = id_b_ff;
      id_off_in  = id_off_ff;
      ex_ins_in  = ex_ins_ff;
      ex_tgt_in  = ex_tgt_ff;
      ex_alu_in  = ex_alu_ff;
      ex_b_in    = ex_b_ff;
      mem_ins_in = mem_ins_ff;
      mem_dat_in = mem_dat_ff;
      wb_ins_in  = wb_ins_ff;
      wb_dat_in  = wb_dat_ff;
      cnt_in     = cnt_ff;
      halt_in    = halt_ff;

      if (tick) begin
         if (stall) begin
            id_ins_in = fspc_pkg::NOOP_WORD;
            id_nxt_in = 16'd0;
            id_a_in   = 32'd0;
            id_b_in   = 32'd0;
            id_off_in = 32'd0;
         end else begin
            if_ins_in = imem_rdata[24:0];
            if_nxt_in = seq;
            pc_in     = seq;
            id_ins_in = if_ins_ff;
            id_nxt_in = if_nxt_ff;
            id_a_in   = rf_ff[fspc_pkg::ra_of(if_ins_ff)];
            id_b_in   = rf_ff[fspc_pkg::rb_of(if_ins_ff)];
            id_off_in = fspc_pkg::sext16(if_ins_ff);
         end

         ex_ins_in = id_ins_ff;
         ex_b_in   = b;
         ex_tgt_in = seq;
         case (fspc_pkg::op_of(id_ins_ff))
            fspc_pkg::OP_ADD:  ex_alu_in = a + b;
            fspc_pkg::OP_NAND: ex_alu_in = ~(a & b);
            default:           ex_alu_in = a + id_off_ff;
         endcase
         // taken branch squashes fetch and decode
         if (fspc_pkg::op_of(id_ins_ff) == fspc_pkg::OP_BEQ && a == b) begin
            ex_tgt_in = id_nxt_ff + id_off_ff[15:0];
            id_ins_in = fspc_pkg::NOOP_WORD;
            if_ins_in = fspc_pkg::NOOP_WORD;
         end

         mem_ins_in = ex_ins_ff;
         mem_dat_in = (fspc_pkg::op_of(ex_ins_ff) == fspc_pkg::OP_LW) ? dmem_rdata : ex_alu_ff;

         wb_ins_in = mem_ins_ff;
         wb_dat_in = mem_dat_ff;
         cnt_in    = cnt_ff + 32'd1;
         halt_in   = fspc_pkg::op_of(ex_ins_ff) == fspc_pkg::OP_HALT;
      end

      // read ahead at the addresses the next tick needs
      ifetch_addr = (fspc_pkg::op_of(ex_ins_in) == fspc_pkg::OP_BEQ) ? ex_tgt_in : pc_in;

      imem_we    = is_load;
      dmem_we    = is_load || (tick && st_valid);
      dmem_waddr = is_load ? req_data.load_address[AW-1:0] : ex_alu_ff[AW-1:0];
      dmem_wdata = is_load ? req_data.load_word : ex_b_ff;

      rsp_data_in                 = '0;
      rsp_data_in.halted          = halt_in;
      rsp_data_in.cycle_count     = cnt_in;
      rsp_data_in.program_counter = pc_in;
      if (tick) begin
         rsp_data_in.reg_write_valid = wr_valid;
         if (wr_valid) begin
            rsp_data_in.reg_write_index = wr_idx;
            rsp_data_in.reg_write_value = mem_dat_ff;
         end
         rsp_data_in.store_valid = st_valid;
         if (st_valid) begin
            rsp_data_in.store_address = ex_alu_ff[15:0];
            rsp_data_in.store_value   = ex_b_ff;
         end
      end

      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);
   end

   // memory index is the low address bits; depth is a power of two
   fspc_ram #(.DEPTH(MEMORY_WORDS), .WIDTH(32)) u_imem (
      .clock (clock),
      .we    (imem_we),
      .waddr (req_data.load_address[AW-1:0]),
      .wdata (req_data.load_word),
      .raddr (ifetch_addr[AW-1:0]),
      .rdata (imem_rdata)
   );

   fspc_ram #(.DEPTH(MEMORY_WORDS), .WIDTH(32)) u_dmem (
      .clock (clock),
      .we    (dmem_we),
      .waddr (dmem_waddr),
      .wdata (dmem_wdata),
      .raddr (ex_alu_in[AW-1:0]),
      .rdata (dmem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         if_ins_ff    <= fspc_pkg::NOOP_WORD;
         if_nxt_ff    <= '0;
         id_ins_ff    <= fspc_pkg::NOOP_WORD;
         id_nxt_ff    <= '0;
         id_a_ff      <= '0;
         id_b_ff      <= '0;
         id_off_ff    <= '0;
         ex_ins_ff    <= fspc_pkg::NOOP_WORD;
         ex_tgt_ff    <= '0;
         ex_alu_ff    <= '0;
         ex_b_ff      <= '0;
         mem_ins_ff   <= fspc_pkg::NOOP_WORD;
         mem_dat_ff   <= '0;
         wb_ins_ff    <= fspc_pkg::NOOP_WORD;
         wb_dat_ff    <= '0;
         cnt_ff       <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         if_ins_ff    <= if_ins_in;
         if_nxt_ff    <= if_nxt_in;
         id_ins_ff    <= id_ins_in;
         id_nxt_ff    <= id_nxt_in;
         id_a_ff      <= id_a_in;
         id_b_ff      <= id_b_in;
         id_off_ff    <= id_off_in;
         ex_ins_ff    <= ex_ins_in;
         ex_tgt_ff    <= ex_tgt_in;
         ex_alu_ff    <= ex_alu_in;
         ex_b_ff      <= ex_b_in;
         mem_ins_ff   <= mem_ins_in;
         mem_dat_ff   <= mem_dat_in;
         wb_ins_ff    <= wb_ins_in;
         wb_dat_ff    <= wb_dat_in;
         cnt_ff       <= cnt_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tick && wr_valid) begin
            rf_ff[wr_idx] <= mem_dat_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/fspc_ram.sv
// synchronous single-port-write, single-port-read memory with write-first read
module fspc_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // a write to the entry being read is returned by that same read
      if (we && waddr == raddr) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/fspc_checker.sv
// port-level checks for the five-stage pipelined cpu, bound to the top level
module fspc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input fspc_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_ready
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_wr_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_write_valid |->
         rsp_data.reg_write_index == 3'd0 && rsp_data.reg_write_value == 32'sd0)
      else $error("register write fields set without a write");

   a_st_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.store_valid |->
         rsp_data.store_address == 16'd0 && rsp_data.store_value == 32'sd0)
      else $error("store fields set without a store");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.halted ##1 rsp_valid |-> rsp_data.halted)
      else $error("halt dropped without reset");

endmodule

bind five_stage_pipelined_cpu fspc_checker u_fspc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

>>> tb/tb.sv
// testbench for the five-stage pipelined cpu: directed table, random programs, then a halt
`timescale 1ns / 100ps

module tb;

   localparam logic [2:0] OP_SPARE = 3'd5;

   typedef struct {
      fspc_pkg::req_type rq;
      bit                has_exp;
      fspc_pkg::rsp_type exp;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   fspc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   fspc_pkg::rsp_type rsp_data;

   five_stage_pipelined_cpu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // cpu shadow state
   bit [31:0] imem [65536];
   bit [31:0] dmem [65536];
   bit        imem_set [65536];
   bit        dmem_set [65536];
   bit [31:0] regs [8];
   bit [15:0] pc_m, if_nxt, id_nxt, ex_tgt;
   bit [24:0] if_ins, id_ins, ex_ins, mem_ins, wb_ins;
   bit [31:0] id_a, id_b, id_off, ex_alu, ex_b, mem_data, wb_data, ticks;
   bit        halt_q;

   fspc_pkg::rsp_type rsp_expected [$];
   int                n_accepted = 0;
   int                n_items = 0;
   int                n_errors = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                cur_has_exp = 0;
   fspc_pkg::rsp_type cur_exp;
   bit                pressure_go = 0;

   function automatic bit [31:0] bypass(input bit [2:0] r, input bit [31:0] val,
                                        input bit [24:0] ins, input bit [31:0] data,
                                        input bit with_lw);
      bit [2:0] op;
      op = ins[24:22];
      if ((op == fspc_pkg::OP_ADD || op == fspc_pkg::OP_NAND) && ins[2:0] == r) return data;
      if (with_lw && op == fspc_pkg::OP_LW && ins[18:16] == r) return data;
      return val;
   endfunction

   task automatic cpu_step(input fspc_pkg::req_type r, output fspc_pkg::rsp_type o);
      bit [15:0] faddr, seq, n_pc, n_ifnext, n_idnext, n_target;
      bit [24:0] fetched, n_if, n_id;
      bit [31:0] n_a, n_b, n_off, n_alu, n_memdata, a, b;
      bit [2:0]  ld;
      bit        stall;
      o = '0;
      stall = 1'b0;
      if (r.command == fspc_pkg::CMD_LOAD) begin
         imem[r.load_address] = r.load_word;
         dmem[r.load_address] = r.load_word;
         imem_set[r.load_address] = 1'b1;
         dmem_set[r.load_address] = 1'b1;
      end else if (!halt_q) begin
         faddr = (ex_ins[24:22] == fspc_pkg::OP_BEQ) ? ex_tgt : pc_m;
         fetched = imem[faddr][24:0];
         seq = faddr + 16'd1;
         // load-use: lw only reads regA
         if (id_ins[24:22] == fspc_pkg::OP_LW) begin
            ld = id_ins[18:16];
            if (if_ins[24:22] == fspc_pkg::OP_LW) stall = (ld == if_ins[21:19]);
            else if (if_ins[24:22] != fspc_pkg::OP_NOOP)
               stall = (ld == if_ins[21:19] || ld == if_ins[18:16]);
         end
         if (stall) begin
            n_if = if_ins; n_ifnext = if_nxt; n_pc = pc_m;
            n_id = fspc_pkg::NOOP_WORD; n_idnext = '0; n_a = '0; n_b = '0; n_off = '0;
         end else begin
            n_if = fetched; n_ifnext = seq; n_pc = seq;
            n_id = if_ins; n_idnext = if_nxt;
            n_a = regs[if_ins[21:19]];
            n_b = regs[if_ins[18:16]];
            n_off = {{16{if_ins[15]}}, if_ins[15:0]};
         end
         // nearest stage wins, so it goes last
         a = bypass(id_ins[21:19], id_a, wb_ins, wb_data, 1'b1);
         b = bypass(id_ins[18:16], id_b, wb_ins, wb_data, 1'b1);
         a = bypass(id_ins[21:19], a, mem_ins, mem_data, 1'b1);
         b = bypass(id_ins[18:16], b, mem_ins, mem_data, 1'b1);
         a = bypass(id_ins[21:19], a, ex_ins, ex_alu, 1'b0);
         b = bypass(id_ins[18:16], b, ex_ins, ex_alu, 1'b0);
         n_target = seq;
         case (id_ins[24:22])
            fspc_pkg::OP_ADD:  n_alu = a + b;
            fspc_pkg::OP_NAND: n_alu = ~(a & b);
            default:           n_alu = a + id_off;
         endcase
         if (id_ins[24:22] == fspc_pkg::OP_BEQ && a == b) begin
            n_target = id_nxt + id_off[15:0];
            n_id = fspc_pkg::NOOP_WORD;
            n_if = fspc_pkg::NOOP_WORD;
         end
         n_memdata = ex_alu;
         if (ex_ins[24:22] == fspc_pkg::OP_SW) begin
            o.store_valid = 1'b1;
            o.store_address = ex_alu[15:0];
            o.store_value = ex_b;
            dmem[ex_alu[15:0]] = ex_b;
            dmem_set[ex_alu[15:0]] = 1'b1;
         end else if (ex_ins[24:22] == fspc_pkg::OP_LW) begin
            n_memdata = dmem[ex_alu[15:0]];
         end
         if (mem_ins[24:22] == fspc_pkg::OP_LW) begin
            o.reg_write_valid = 1'b1; o.reg_write_index = mem_ins[18:16];
         end else if (mem_ins[24:22] == fspc_pkg::OP_ADD ||
                      mem_ins[24:22] == fspc_pkg::OP_NAND) begin
            o.reg_write_valid = 1'b1; o.reg_write_index = mem_ins[2:0];
         end
         if (o.reg_write_valid) begin
            o.reg_write_value = mem_data;
            regs[o.reg_write_index] = mem_data;
         end
         wb_ins = mem_ins; wb_data = mem_data;
         mem_ins = ex_ins; mem_data = n_memdata;
         ex_ins = id_ins; ex_tgt = n_target; ex_alu = n_alu; ex_b = b;
         id_ins = n_id; id_nxt = n_idnext; id_a = n_a; id_b = n_b; id_off = n_off;
         if_ins = n_if; if_nxt = n_ifnext;
         pc_m = n_pc;
         ticks = ticks + 32'd1;
         halt_q = (mem_ins[24:22] == fspc_pkg::OP_HALT);
      end
      o.halted = halt_q;
      o.cycle_count = ticks;
      o.program_counter = pc_m;
   endtask

   task automatic field_check(input string name, input logic [31:0] e, input logic [31:0] a,
                              inout bit bad);
      if (e !== a) begin
         bad = 1'b1;
         if (n_errors < 10)
            $display("mismatch %s: expected %h, got %h", name, e, a);
      end
   endtask

   // accept beats, predict, and check results
   always @(posedge clock) begin
      fspc_pkg::rsp_type e;
      fspc_pkg::rsp_type p;
      bit bad;
      if (!reset && req_valid && req_ready) begin
         cpu_step(req_data, p);
         rsp_expected.push_back(cur_has_exp ? cur_exp : p);
         n_accepted <= n_accepted + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_expected.size() == 0) begin
            if (n_errors < 10) $display("unexpected result beat %p", rsp_data);
            n_errors++;
         end else begin
            e = rsp_expected.pop_front();
            bad = 1'b0;
            field_check("halted", 32'(e.halted), 32'(rsp_data.halted), bad);
            field_check("cycle_count", e.cycle_count, rsp_data.cycle_count, bad);
            field_check("program_counter", 32'(e.program_counter),
                        32'(rsp_data.program_counter), bad);
            field_check("reg_write_valid", 32'(e.reg_write_valid),
                        32'(rsp_data.reg_write_valid), bad);
            field_check("reg_write_index", 32'(e.reg_write_index),
                        32'(rsp_data.reg_write_index), bad);
            field_check("reg_write_value", e.reg_write_value, rsp_data.reg_write_value, bad);
            field_check("store_valid", 32'(e.store_valid), 32'(rsp_data.store_valid), bad);
            field_check("store_address", 32'(e.store_address),
                        32'(rsp_data.store_address), bad);
            field_check("store_value", e.store_value, rsp_data.store_value, bad);
            if (bad) n_errors++;
         end
      end
   end

   // result side back-pressure, with one long hold-off
   initial begin
      int hold;
      bit pressure_done;
      hold = 0;
      pressure_done = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic put(input fspc_pkg::req_type r, input bit has_exp = 1'b0,
                      input fspc_pkg::rsp_type e = '0);
      int target;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      cur_has_exp = has_exp;
      cur_exp = e;
      target = n_accepted + 1;
      while (n_accepted != target) @(negedge clock);
      n_items++;
   endtask

   function automatic fspc_pkg::req_type mk(input logic c, input logic [15:0] ad,
                                            input logic [31:0] w);
      fspc_pkg::req_type r;
      r.command = c;
      r.load_address = ad;
      r.load_word = w;
      return r;
   endfunction

   // random word that never carries the halt opcode
   function automatic logic [31:0] rand_instr();
      logic [31:0] w;
      logic [2:0] op;
      w = $urandom;
      op = 3'($urandom_range(6));
      if (op == fspc_pkg::OP_HALT) op = fspc_pkg::OP_NOOP;
      w[24:22] = op;
      if (op == fspc_pkg::OP_BEQ) w[15:0] = 16'($signed($urandom_range(12)) - 4);
      return w;
   endfunction

   // before a tick, load the entries it will read if they were never written
   task automatic send(input fspc_pkg::req_type r, input bit has_exp = 1'b0,
                       input fspc_pkg::rsp_type e = '0);
      bit [15:0] fa;
      if (r.command == fspc_pkg::CMD_TICK && !halt_q) begin
         fa = (ex_ins[24:22] == fspc_pkg::OP_BEQ) ? ex_tgt : pc_m;
         if (!imem_set[fa]) put(mk(fspc_pkg::CMD_LOAD, fa, rand_instr()));
         if (ex_ins[24:22] == fspc_pkg::OP_LW && !dmem_set[ex_alu[15:0]])
            put(mk(fspc_pkg::CMD_LOAD, ex_alu[15:0], rand_instr()));
      end
      put(r, has_exp, e);
   endtask

   initial begin
      dir_row_type rows [$];
      dir_row_type row;
      fspc_pkg::rsp_type e;
      logic [15:0] base;
      int k, guard;

      if_ins  = fspc_pkg::NOOP_WORD;
      id_ins  = fspc_pkg::NOOP_WORD;
      ex_ins  = fspc_pkg::NOOP_WORD;
      mem_ins = fspc_pkg::NOOP_WORD;
      wb_ins  = fspc_pkg::NOOP_WORD;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      e = '0;
      row.has_exp = 1'b1;
      row.exp = e;
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd0, {7'd0, fspc_pkg::OP_LW, 3'd0, 3'd1, 16'd100});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd100, 32'h7FFF_FFFF); rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd1, {7'd0, fspc_pkg::OP_ADD, 3'd1, 3'd1, 16'd2});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd2, {7'd0, fspc_pkg::OP_NAND, 3'd2, 3'd1, 16'd3});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd3, {7'h7F, fspc_pkg::OP_SW, 3'd0, 3'd3, 16'hFFFF});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd4, {7'd0, fspc_pkg::OP_BEQ, 3'd0, 3'd0, 16'd2});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd5, {7'd0, fspc_pkg::OP_ADD, 3'd1, 3'd2, 16'd4});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd6, {7'd0, fspc_pkg::OP_ADD, 3'd1, 3'd2, 16'd4});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd7, {7'd0, OP_SPARE, 3'd1, 3'd0, 16'h8000});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'd8, {7'd0, fspc_pkg::OP_SW, 3'd0, 3'd2, 16'h7FFF});
      rows.push_back(row);
      row.rq = mk(fspc_pkg::CMD_LOAD, 16'hFFFF, 32'h8000_0000); rows.push_back(row);
      // first tick after reset: only the counter and pc move
      e.cycle_count = 32'd1;
      e.program_counter = 16'd1;
      row.exp = e;
      row.rq = mk(fspc_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF); rows.push_back(row);
      row.has_exp = 1'b0;
      for (int i = 0; i < 13; i++) begin
         row.rq = mk(fspc_pkg::CMD_TICK, 16'd0, 32'd0);
         rows.push_back(row);
      end
      foreach (rows[i]) send(rows[i].rq, rows[i].has_exp, rows[i].exp);

      // random programs placed where fetch goes next
      while (n_items < 1500) begin
         case ((n_items / 200) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         if (n_items > 700) pressure_go = 1'b1;
         if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) send(mk(fspc_pkg::CMD_LOAD, 16'($urandom), rand_instr()));
            else send(mk(fspc_pkg::CMD_TICK, 16'($urandom), $urandom));
         end else begin
            base = (ex_ins[24:22] == fspc_pkg::OP_BEQ) ? ex_tgt : pc_m;
            k = $urandom_range(3, 10);
            for (int i = 0; i < k; i++)
               send(mk(fspc_pkg::CMD_LOAD, base + 16'(i), rand_instr()));
            repeat (k + $urandom_range(2, 6))
               send(mk(fspc_pkg::CMD_TICK, 16'($urandom), $urandom));
         end
      end

      // halt, then a load and a tick while frozen
      send_idle_pct = 0;
      recv_stall_pct = 0;
      base = (ex_ins[24:22] == fspc_pkg::OP_BEQ) ? ex_tgt : pc_m;
      for (int i = 0; i < 4; i++)
         send(mk(fspc_pkg::CMD_LOAD, base + 16'(i), {7'd0, fspc_pkg::OP_HALT, 22'd0}));
      repeat (8) send(mk(fspc_pkg::CMD_TICK, 16'd0, 32'd0));
      send(mk(fspc_pkg::CMD_LOAD, 16'h1234, 32'h5555_AAAA));
      send(mk(fspc_pkg::CMD_TICK, 16'd0, 32'd0));

      @(negedge clock);
      req_valid = 1'b0;
      guard = 0;
      while (rsp_expected.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      if (n_errors == 0 && rsp_expected.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
